/* src/lcfd_pkg.sv */
// ----------------------------------------------------------------------------
// lcfd_pkg
// Shared types and constants of the check-byte frame deframer.
// ----------------------------------------------------------------------------
package lcfd_pkg;

  localparam int MAX_PAYLOAD_DEF = 1024;

  localparam logic [7:0] HEADER_BYTE    = 8'h55;
  localparam logic [9:0] HUNT_LIMIT_RST = 10'd1000;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SW0,
    PH_SW1,
    PH_LEN0,
    PH_LEN1,
    PH_DATA,
    PH_CHECK
  } phase_t;

  typedef struct packed {
    logic       start_frame;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        length_clamped;
    logic        header_missed;
    logic        check_ok;
    logic [7:0]  computed_check;
    logic [7:0]  received_check;
    logic [10:0] data_length;
    logic [15:0] status_word;
    logic [9:0]  payload_index;
    logic [7:0]  payload_byte;
  } result_t;

endpackage

/* src/lrc_checked_frame_deframer.sv */
// Accepts one received byte per clock cycle while the result side keeps up.
// A byte accepted into the input register is parsed when the parser steps,
// which updates the frame state and loads its result into the result
// register (input register, parser update, result register), where the sink
// can take it. The rate is set by the frame state update in the parser. A
// result the sink has not taken holds the parser and every byte behind it,
// so the input stalls once both registers are full. Only payload
// bytes and the frame-end summary produce result transactions; header,
// status, length and hunted bytes produce none.
// ----------------------------------------------------------------------------
// lrc_checked_frame_deframer
// Header-hunting, length-prefixed response frame parser with check byte.
// ----------------------------------------------------------------------------
module lrc_checked_frame_deframer #(
  parameter int MAX_PAYLOAD = lcfd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data,      // hunt_limit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // rx_byte
  input  logic        s_axis_tuser,  // start_frame
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // payload_byte[7:0], payload_index[17:8], status_word[33:18],
  // data_length[44:34], received_check[52:45], computed_check[60:53],
  // check_ok[61], header_missed[62], length_clamped[63]
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tlast   // last
);

  lcfd_pkg::in_item_t item;
  lcfd_pkg::result_t  res;
  logic               item_valid, room, step, res_valid, res_last;

  assign cfg_ready = 1'b1;
  assign step      = item_valid && room;

  lcfd_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid    (item_valid),
    .item          (item),
    .take          (step)
  );

  lcfd_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res_last  (res_last),
    .res       (res)
  );

  lcfd_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (step && res_valid),
    .res           (res),
    .res_last      (res_last),
    .room          (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* src/lcfd_in_stage.sv */
// ----------------------------------------------------------------------------
// lcfd_in_stage
// Input register: holds one received byte and its start flag for the parser.
// ----------------------------------------------------------------------------
module lcfd_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,
  input  logic              s_axis_tuser,
  output logic              item_valid,
  output lcfd_pkg::in_item_t item,
  input  logic              take
);

  assign s_axis_tready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.start_frame <= s_axis_tuser;
      item.rx_byte     <= s_axis_tdata;
    end
  end

endmodule

/* src/lcfd_parser.sv */
// ----------------------------------------------------------------------------
// lcfd_parser
// Frame state and per-byte update: header hunt, status, length,
// payload and check byte, with the running XOR.
// ----------------------------------------------------------------------------
module lcfd_parser #(
  parameter int MAX_PAYLOAD = lcfd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [9:0]         cfg_data,
  input  logic               step,
  input  lcfd_pkg::in_item_t item,
  output logic               res_valid,
  output logic               res_last,
  output lcfd_pkg::result_t  res
);

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

  logic [9:0]        hunt_limit;
  lcfd_pkg::phase_t  phase, phase_next, ph;
  logic [9:0]        hunt_count, hunt_count_next, hc, hc_inc;
  logic [15:0]       status_held, status_held_next, st;
  logic [7:0]        length_high_held, length_high_held_next, lhi;
  logic [LEN_W-1:0]  length_held, length_held_next, lh;
  logic [LEN_W-1:0]  bytes_seen, bytes_seen_next, seen, seen_inc;
  logic [7:0]        running_xor, running_xor_next, rx;
  logic              miss, miss_next, mf;
  logic              clamp, clamp_next, cf;
  logic [15:0]       len_raw, len_ext, seen_ext;
  logic [7:0]        b, comp;

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_limit <= lcfd_pkg::HUNT_LIMIT_RST;
    end else if (cfg_valid) begin
      hunt_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= lcfd_pkg::PH_HUNT;
      hunt_count       <= '0;
      status_held      <= '0;
      length_high_held <= '0;
      length_held      <= '0;
      bytes_seen       <= '0;
      running_xor      <= '0;
      miss             <= 1'b0;
      clamp            <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      hunt_count       <= hunt_count_next;
      status_held      <= status_held_next;
      length_high_held <= length_high_held_next;
      length_held      <= length_held_next;
      bytes_seen       <= bytes_seen_next;
      running_xor      <= running_xor_next;
      miss             <= miss_next;
      clamp            <= clamp_next;
    end
  end

  always_comb begin
    b    = item.rx_byte;
    ph   = item.start_frame ? lcfd_pkg::PH_HUNT : phase;
    hc   = item.start_frame ? '0 : hunt_count;
    st   = item.start_frame ? '0 : status_held;
    lhi  = item.start_frame ? '0 : length_high_held;
    lh   = item.start_frame ? '0 : length_held;
    seen = item.start_frame ? '0 : bytes_seen;
    rx   = item.start_frame ? '0 : running_xor;
    mf   = item.start_frame ? 1'b0 : miss;
    cf   = item.start_frame ? 1'b0 : clamp;

    hc_inc   = hc + 10'd1;
    seen_inc = seen + LEN_W'(1);
    len_raw  = {lhi, b};
    len_ext  = 16'(lh);
    seen_ext = 16'(seen);
    comp     = ~rx;

    phase_next            = ph;
    hunt_count_next       = hc;
    status_held_next      = st;
    length_high_held_next = lhi;
    length_held_next      = lh;
    bytes_seen_next       = seen;
    running_xor_next      = rx;
    miss_next             = mf;
    clamp_next            = cf;
    res_valid             = 1'b0;
    res_last              = 1'b0;
    res                   = '0;

    case (ph)
      lcfd_pkg::PH_HUNT: begin
        if (b == lcfd_pkg::HEADER_BYTE) begin
          phase_next = lcfd_pkg::PH_SW0;
        end else begin
          hunt_count_next = hc_inc;
          if (hc_inc >= hunt_limit) begin
            miss_next  = 1'b1;
            phase_next = lcfd_pkg::PH_SW0;
          end
        end
      end
      lcfd_pkg::PH_SW0: begin
        status_held_next = {b, 8'h00};
        running_xor_next = rx ^ b;
        phase_next       = lcfd_pkg::PH_SW1;
      end
      lcfd_pkg::PH_SW1: begin
        status_held_next = {st[15:8], b};
        running_xor_next = rx ^ b;
        phase_next       = lcfd_pkg::PH_LEN0;
      end
      lcfd_pkg::PH_LEN0: begin
        length_high_held_next = b;
        running_xor_next      = rx ^ b;
        phase_next            = lcfd_pkg::PH_LEN1;
      end
      lcfd_pkg::PH_LEN1: begin
        running_xor_next = rx ^ b;
        bytes_seen_next  = '0;
        if (len_raw > 16'(MAX_PAYLOAD)) begin
          length_held_next = LEN_W'(MAX_PAYLOAD);
          clamp_next       = 1'b1;
        end else begin
          length_held_next = LEN_W'(len_raw);
        end
        phase_next = (len_raw == 16'd0) ? lcfd_pkg::PH_CHECK : lcfd_pkg::PH_DATA;
      end
      lcfd_pkg::PH_DATA: begin
        running_xor_next  = rx ^ b;
        res_valid         = 1'b1;
        res.payload_byte  = b;
        res.payload_index = seen_ext[9:0];
        bytes_seen_next   = seen_inc;
        if (seen_inc >= lh) begin
          phase_next = lcfd_pkg::PH_CHECK;
        end
      end
      lcfd_pkg::PH_CHECK: begin
        res_valid             = 1'b1;
        res_last              = 1'b1;
        res.status_word       = st;
        res.data_length       = len_ext[10:0];
        res.received_check    = b;
        res.computed_check    = comp;
        res.check_ok          = (comp == b);
        res.header_missed     = mf;
        res.length_clamped    = cf;
        phase_next            = lcfd_pkg::PH_HUNT;
        hunt_count_next       = '0;
        status_held_next      = '0;
        length_high_held_next = '0;
        length_held_next      = '0;
        bytes_seen_next       = '0;
        running_xor_next      = '0;
        miss_next             = 1'b0;
        clamp_next            = 1'b0;
      end
      default: begin
        phase_next            = lcfd_pkg::PH_HUNT;
        hunt_count_next       = '0;
        status_held_next      = '0;
        length_high_held_next = '0;
        length_held_next      = '0;
        bytes_seen_next       = '0;
        running_xor_next      = '0;
        miss_next             = 1'b0;
        clamp_next            = 1'b0;
      end
    endcase
  end

  a_data_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == lcfd_pkg::PH_DATA |-> length_held != '0)
    else $error("payload phase with zero length");

  a_data_seen_below_len: assert property (@(posedge clk) disable iff (rst)
    phase == lcfd_pkg::PH_DATA |-> bytes_seen < length_held)
    else $error("payload count reached length inside payload phase");

  a_summary_clears: assert property (@(posedge clk) disable iff (rst)
    step && res_valid && res.data_length == 11'd0 && ph == lcfd_pkg::PH_CHECK
      |=> phase == lcfd_pkg::PH_HUNT && hunt_count == '0 && running_xor == '0)
    else $error("frame state not cleared after summary");

  a_clamp_bounded: assert property (@(posedge clk) disable iff (rst)
    clamp |-> length_held == LEN_W'(MAX_PAYLOAD))
    else $error("clamp flag without clamped length");

endmodule

/* src/lcfd_out_stage.sv */
// ----------------------------------------------------------------------------
// lcfd_out_stage
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module lcfd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  lcfd_pkg::result_t res,
  input  logic              res_last,
  output logic              room,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [63:0]       m_axis_tdata,
  output logic              m_axis_tlast
);

  lcfd_pkg::result_t held;
  logic              held_last;

  assign room = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held      <= res;
      held_last <= res_last;
    end
  end

  assign m_axis_tdata = held;
  assign m_axis_tlast = held_last;

endmodule
